// ===== src/hsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// hsfd_pkg
// Shared types and constants for the H.264 stream format detector.
// ----------------------------------------------------------------------------
package hsfd_pkg;

    // Default window for the first byte of an Annex B start code.
    localparam int DEFAULT_SCAN_LIMIT = 64;

    // Length-prefixed framing uses 4-byte big-endian unit lengths.
    localparam int LENGTH_BYTES = 4;
    localparam int LEN_CNT_W    = $clog2(LENGTH_BYTES);
    localparam int LEN_W        = 8 * LENGTH_BYTES;

    // NAL unit header checks.
    localparam logic [7:0] NAL_FORBIDDEN_MASK = 8'h80;
    localparam logic [7:0] NAL_TYPE_MASK      = 8'h1f;

    // Start code bytes.
    localparam logic [7:0] START_CODE_TAIL = 8'h01;

    // Step control that goes from the input stage to both checkers.
    typedef struct packed {
        logic enable;   // a byte is consumed in this cycle
        logic last;     // that byte closes the packet
    } hsfd_step_t;

endpackage

// ===== src/hsfd_avcc_parser.sv =====
// ----------------------------------------------------------------------------
// hsfd_avcc_parser
// Parses a packet as 4-byte length-prefixed NAL units, one byte per step.
// ----------------------------------------------------------------------------
module hsfd_avcc_parser
    import hsfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  hsfd_step_t step,
    input  logic [7:0] data_byte,
    output logic       prefixed_valid
);

    logic [LEN_W-1:0]     len_acc_reg,  len_acc_next;
    logic [LEN_CNT_W-1:0] len_cnt_reg,  len_cnt_next;
    logic [LEN_W-2:0]     remain_reg,   remain_next;
    logic                 in_payload_reg, in_payload_next;
    logic                 header_due_reg, header_due_next;
    logic                 unit_seen_reg,  unit_seen_next;
    logic                 failed_reg,     failed_next;

    logic [LEN_W-1:0]     len_shift;
    logic [LEN_W-2:0]     remain_dec;

    assign len_shift  = {len_acc_reg[LEN_W-9:0], data_byte};
    assign remain_dec = remain_reg - 1'b1;

    always_comb begin
        len_acc_next    = len_acc_reg;
        len_cnt_next    = len_cnt_reg;
        remain_next     = remain_reg;
        in_payload_next = in_payload_reg;
        header_due_next = header_due_reg;
        unit_seen_next  = unit_seen_reg;
        failed_next     = failed_reg;
        if (!failed_reg) begin
            if (!in_payload_reg) begin
                len_acc_next = len_shift;
                len_cnt_next = len_cnt_reg + 1'b1;
                if (len_cnt_next == '0) begin
                    // A complete length: zero or a set top bit is illegal.
                    if (len_shift == '0 || len_shift[LEN_W-1]) begin
                        failed_next = 1'b1;
                    end else begin
                        remain_next     = len_shift[LEN_W-2:0];
                        in_payload_next = 1'b1;
                        header_due_next = 1'b1;
                    end
                    len_acc_next = '0;
                end
            end else begin
                if (header_due_reg) begin
                    if ((data_byte & NAL_FORBIDDEN_MASK) != '0 ||
                        (data_byte & NAL_TYPE_MASK) == '0) begin
                        failed_next = 1'b1;
                    end
                    header_due_next = 1'b0;
                end
                remain_next = remain_dec;
                if (remain_dec == '0) begin
                    in_payload_next = 1'b0;
                    unit_seen_next  = 1'b1;
                end
            end
        end
    end

    // Verdict as it stands once the current byte is taken in.
    assign prefixed_valid = !failed_next && unit_seen_next && !in_payload_next &&
                            (len_cnt_next == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn || (step.enable && step.last)) begin
            len_acc_reg    <= '0;
            len_cnt_reg    <= '0;
            remain_reg     <= '0;
            in_payload_reg <= 1'b0;
            header_due_reg <= 1'b0;
            unit_seen_reg  <= 1'b0;
            failed_reg     <= 1'b0;
        end else if (step.enable) begin
            len_acc_reg    <= len_acc_next;
            len_cnt_reg    <= len_cnt_next;
            remain_reg     <= remain_next;
            in_payload_reg <= in_payload_next;
            header_due_reg <= header_due_next;
            unit_seen_reg  <= unit_seen_next;
            failed_reg     <= failed_next;
        end
    end

endmodule

// ===== src/hsfd_start_code_scan.sv =====
// ----------------------------------------------------------------------------
// hsfd_start_code_scan
// Looks for a 3- or 4-byte Annex B start code near the head of a packet.
// ----------------------------------------------------------------------------
module hsfd_start_code_scan
    import hsfd_pkg::*;
#(
    parameter int SCAN_LIMIT = DEFAULT_SCAN_LIMIT
)(
    input  logic       aclk,
    input  logic       aresetn,
    input  hsfd_step_t step,
    input  logic [7:0] data_byte,
    output logic       start_code_seen
);

    localparam int POS_MAX = SCAN_LIMIT + 3;
    localparam int POS_W   = $clog2(POS_MAX + 1);
    localparam logic [POS_W-1:0] POS_SAT     = POS_W'(POS_MAX);
    localparam logic [POS_W-1:0] POS_LIM3    = POS_W'(SCAN_LIMIT + 2);

    logic [POS_W-1:0] pos_reg;
    logic [23:0]      recent_reg;
    logic             seen_reg;
    logic             hit3;
    logic             hit4;

    // The position counts the current byte; the code's first byte must
    // start below the scan limit.
    assign hit3 = (data_byte == START_CODE_TAIL) && (recent_reg[15:0] == '0) &&
                  (pos_reg < POS_LIM3);
    assign hit4 = (data_byte == START_CODE_TAIL) && (recent_reg == '0) &&
                  (pos_reg < POS_SAT);

    assign start_code_seen = seen_reg || hit3 || hit4;

    always_ff @(posedge aclk) begin
        if (!aresetn || (step.enable && step.last)) begin
            pos_reg    <= '0;
            recent_reg <= '1;
            seen_reg   <= 1'b0;
        end else if (step.enable) begin
            recent_reg <= {recent_reg[15:0], data_byte};
            seen_reg   <= start_code_seen;
            if (pos_reg < POS_SAT) begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

endmodule

// ===== src/h264_stream_format_detector_unit.sv =====
// ----------------------------------------------------------------------------
// h264_stream_format_detector_unit
// Classifies an H.264 packet as length-prefixed (AVCC) or Annex B framed.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_valid, s_ready, s_data_byte, s_last_byte) takes one
//   packet byte per request; s_last_byte marks the final byte of a packet.
//   The result channel (m_valid, m_ready, m_annexb_detected,
//   m_length_prefixed_valid) carries one request per packet, produced by its
//   final byte. Non-final bytes produce no result.
//   Throughput is one byte per clock while no final byte waits for the result
//   register. An accepted byte sits in the input register and is parsed from
//   there; for a final byte the result register loads as the byte is parsed,
//   and m_valid is driven from the result register.
//   The length-prefixed parser and the start code scanner both keep their
//   per-packet state in registers that clear themselves after the final byte.
//   When the receiver stalls, the result register holds; a final byte then
//   waits in the input register and the input channel stops, while non-final
//   bytes keep flowing. Reset (aresetn low, synchronous) empties both
//   registers and returns all per-packet state to its idle values.
// ----------------------------------------------------------------------------
module h264_stream_format_detector_unit
    import hsfd_pkg::*;
#(
    parameter int SCAN_LIMIT = DEFAULT_SCAN_LIMIT
)(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_annexb_detected,
    output logic       m_length_prefixed_valid
);

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;

    // Result register.
    logic       out_valid_reg;
    logic       out_annexb_reg;
    logic       out_prefixed_reg;

    logic       out_free;
    logic       consume;
    hsfd_step_t step;
    logic       prefixed_valid;
    logic       start_code_seen;

    // The result register can take a new result when it is empty or its
    // current result leaves in this cycle.
    assign out_free = !out_valid_reg || m_ready;

    // A non-final byte only updates parser state and never waits; a final
    // byte needs room in the result register.
    assign consume = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready = !in_valid_reg || consume;

    assign step.enable = consume;
    assign step.last   = in_last_reg;

    hsfd_avcc_parser u_avcc (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .data_byte      (in_data_reg),
        .prefixed_valid (prefixed_valid)
    );

    hsfd_start_code_scan #(
        .SCAN_LIMIT (SCAN_LIMIT)
    ) u_scan (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (step),
        .data_byte       (in_data_reg),
        .start_code_seen (start_code_seen)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= consume && in_last_reg;
        end
        if (out_free && consume && in_last_reg) begin
            // Annex B is reported only when the length-prefixed parse fails.
            out_annexb_reg   <= start_code_seen && !prefixed_valid;
            out_prefixed_reg <= prefixed_valid;
        end
    end

    assign m_valid                 = out_valid_reg;
    assign m_annexb_detected       = out_annexb_reg;
    assign m_length_prefixed_valid = out_prefixed_reg;

`ifndef ASSERT_OFF
    // The two verdicts exclude each other.
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_annexb_detected && m_length_prefixed_valid))
        else $error("both framing flags set in one result");

    // A non-final byte in the input register is always parsed at once.
    a_body_never_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !in_last_reg) |-> consume)
        else $error("non-final byte held in input register");

    // A new result appears only after a final byte was consumed.
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(consume && in_last_reg))
        else $error("result without a final byte");

    // An empty input register always accepts.
    a_empty_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stage empty but not ready");
`endif

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the H.264 stream format detector. Packets are sent
// one byte per request on the input channel. A byte-level predictor in the
// bench works out the framing verdict of each packet, and a checker compares
// every result request against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import hsfd_pkg::*;

    // The scan window of the instance; the predictor uses the same value.
    localparam int SCAN_WINDOW = DEFAULT_SCAN_LIMIT;

    // The receiver's deliberate hold-off, long enough to fill the block.
    localparam int LONG_HOLD_CYCLES = 400;

    // Cycles with no accepted request before the run is declared hung. The
    // slowest correct stretch is the long hold-off plus one long sender gap.
    localparam int WATCHDOG_LIMIT = 3000;

    // Input bytes for the random phase.
    localparam int RANDOM_BYTES = 1200;

    // Mismatches beyond this many are only counted.
    localparam int REPORT_LIMIT = 10;

    // Kinds of packet the random phase builds.
    typedef enum int {
        PKT_LENGTH_PREFIXED,
        PKT_ANNEXB,
        PKT_NOISE
    } packet_kind_t;

    // Ways a length-prefixed packet can be spoiled on purpose.
    typedef enum int {
        DAMAGE_NONE,
        DAMAGE_TRUNCATE,
        DAMAGE_TRAILING,
        DAMAGE_BAD_HEADER,
        DAMAGE_BAD_LENGTH
    } damage_t;

    // The two flags that one packet's final byte produces.
    typedef struct packed {
        logic annexb_detected;
        logic length_prefixed_valid;
    } framing_verdict_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data_byte;
    logic       s_last_byte;
    logic       m_valid;
    logic       m_ready;
    logic       m_annexb_detected;
    logic       m_length_prefixed_valid;

    h264_stream_format_detector_unit #(
        .SCAN_LIMIT(SCAN_WINDOW)
    ) uut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_data_byte            (s_data_byte),
        .s_last_byte            (s_last_byte),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_annexb_detected      (m_annexb_detected),
        .m_length_prefixed_valid(m_length_prefixed_valid)
    );

    always #4 aclk = ~aclk;

    // Verdicts of packets whose final byte has been accepted, oldest first.
    framing_verdict_t expected_verdicts[$];

    // Bytes of the packet under construction.
    logic [7:0] packet_bytes[$];

    int  fail_count;
    int  bytes_sent;
    int  idle_cycles;
    bit  sender_gaps_on;
    bit  hold_request;
    bit  receiver_held;

    // ------------------------------------------------------------------------
    // Framing predictor. It mirrors the block's per-packet state: a parser for
    // 4-byte big-endian unit lengths and a start code scanner that runs beside
    // it on every byte.
    // ------------------------------------------------------------------------
    logic [31:0] avcc_length;
    logic [1:0]  avcc_length_bytes;
    logic [30:0] avcc_remaining;
    bit          avcc_in_payload;
    bit          avcc_header_due;
    bit          avcc_unit_seen;
    bit          avcc_failed;
    int          scan_position;
    logic [23:0] scan_history;
    bit          scan_found;

    // Idle values between packets. The history starts as all ones so that the
    // first bytes of a packet cannot complete a start code.
    function automatic void clear_framing_state();
        avcc_length       = '0;
        avcc_length_bytes = '0;
        avcc_remaining    = '0;
        avcc_in_payload   = 1'b0;
        avcc_header_due   = 1'b0;
        avcc_unit_seen    = 1'b0;
        avcc_failed       = 1'b0;
        scan_position     = 0;
        scan_history      = 24'hff_ffff;
        scan_found        = 1'b0;
    endfunction

    function automatic void predict_framing(input logic [7:0] value, input logic closes);
        framing_verdict_t verdict;
        bit               parsed_ok;

        // Once the length parser has failed it ignores the rest of the packet.
        if (!avcc_failed) begin
            if (!avcc_in_payload) begin
                avcc_length       = {avcc_length[23:0], value};
                avcc_length_bytes = avcc_length_bytes + 2'd1;
                if (avcc_length_bytes == 2'd0) begin
                    // A zero length or one with the top bit set cannot be a unit.
                    if (avcc_length == 32'd0 || avcc_length[31]) begin
                        avcc_failed = 1'b1;
                    end else begin
                        avcc_remaining  = avcc_length[30:0];
                        avcc_in_payload = 1'b1;
                        avcc_header_due = 1'b1;
                    end
                    avcc_length = '0;
                end
            end else begin
                if (avcc_header_due) begin
                    if ((value & NAL_FORBIDDEN_MASK) != 8'h00 ||
                        (value & NAL_TYPE_MASK) == 8'h00) begin
                        avcc_failed = 1'b1;
                    end
                    avcc_header_due = 1'b0;
                end
                avcc_remaining = avcc_remaining - 31'd1;
                if (avcc_remaining == 31'd0) begin
                    avcc_in_payload = 1'b0;
                    avcc_unit_seen  = 1'b1;
                end
            end
        end

        // A start code counts only if its first byte lies inside the window.
        if (value == START_CODE_TAIL) begin
            if (scan_history[15:0] == 16'h0000 && scan_position < SCAN_WINDOW + 2) begin
                scan_found = 1'b1;
            end
            if (scan_history == 24'h00_0000 && scan_position < SCAN_WINDOW + 3) begin
                scan_found = 1'b1;
            end
        end
        scan_history = {scan_history[15:0], value};
        if (scan_position < SCAN_WINDOW + 3) begin
            scan_position++;
        end

        if (closes) begin
            parsed_ok = !avcc_failed && avcc_unit_seen && !avcc_in_payload &&
                        avcc_length_bytes == 2'd0;
            verdict.length_prefixed_valid = parsed_ok;
            verdict.annexb_detected       = scan_found && !parsed_ok;
            expected_verdicts.push_back(verdict);
            clear_framing_state();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Packet building.
    // ------------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Payload bytes lean toward 00 and 01 so that start codes turn up by chance.
    function automatic logic [7:0] payload_byte();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 3) return 8'h00;
        if (roll == 3) return START_CODE_TAIL;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] good_header();
        return {1'b0, 2'($urandom), 5'($urandom_range(1, 31))};
    endfunction

    function automatic logic [7:0] bad_header();
        if ($urandom_range(0, 1) == 1) return 8'($urandom) | NAL_FORBIDDEN_MASK;
        return 8'($urandom) & ~NAL_TYPE_MASK;
    endfunction

    function automatic void push_length(input logic [31:0] length);
        packet_bytes.push_back(length[31:24]);
        packet_bytes.push_back(length[23:16]);
        packet_bytes.push_back(length[15:8]);
        packet_bytes.push_back(length[7:0]);
    endfunction

    function automatic void push_unit(input int length, input logic [7:0] header);
        push_length(32'(length));
        packet_bytes.push_back(header);
        repeat (length - 1) packet_bytes.push_back(payload_byte());
    endfunction

    // One to three well-formed units, sometimes spoiled in one of several ways.
    function automatic void build_length_prefixed();
        damage_t damage;
        int      roll;
        int      length;

        repeat ($urandom_range(1, 3)) begin
            length = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 90)
                                                 : $urandom_range(1, 12);
            push_unit(length, good_header());
        end

        roll   = $urandom_range(0, 9);
        damage = (roll < 6) ? DAMAGE_NONE : damage_t'(roll - 5);
        case (damage)
            DAMAGE_TRUNCATE: begin
                repeat ($urandom_range(1, 3)) begin
                    if (packet_bytes.size() > 1) void'(packet_bytes.pop_back());
                end
            end
            DAMAGE_TRAILING: begin
                // Stray bytes leave a partial length, or a huge length whose
                // payload runs past the end of the packet.
                repeat ($urandom_range(1, 7)) packet_bytes.push_back(8'($urandom));
            end
            DAMAGE_BAD_HEADER: begin
                push_unit($urandom_range(1, 12), bad_header());
            end
            DAMAGE_BAD_LENGTH: begin
                push_length(($urandom_range(0, 1) == 1) ? 32'd0
                                                        : (32'($urandom) | 32'h8000_0000));
                repeat ($urandom_range(0, 8)) packet_bytes.push_back(payload_byte());
            end
            default: ;
        endcase
    endfunction

    // A 3- or 4-byte start code after some leading bytes. A quarter of them
    // put the code right around the edge of the scan window.
    function automatic void build_annexb();
        int lead;
        lead = ($urandom_range(0, 3) == 0) ? $urandom_range(SCAN_WINDOW - 4, SCAN_WINDOW + 4)
                                           : $urandom_range(0, 24);
        repeat (lead) packet_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 1) == 1) packet_bytes.push_back(8'h00);
        packet_bytes.push_back(8'h00);
        packet_bytes.push_back(8'h00);
        packet_bytes.push_back(START_CODE_TAIL);
        packet_bytes.push_back(good_header());
        repeat ($urandom_range(0, 16)) packet_bytes.push_back(payload_byte());
    endfunction

    // Short junk most of the time; sometimes long enough to saturate the
    // position counter.
    function automatic void build_noise();
        int count;
        count = ($urandom_range(0, 7) == 0) ? $urandom_range(SCAN_WINDOW, SCAN_WINDOW + 40)
                                            : $urandom_range(1, 20);
        repeat (count) packet_bytes.push_back(payload_byte());
    endfunction

    // ------------------------------------------------------------------------
    // Sender side. Every task here starts and ends on a rising edge, so each
    // nonblocking update of the input channel lands in its own time step.
    // ------------------------------------------------------------------------

    // Offer one byte and hold it until the block takes the request.
    task automatic send_byte(input logic [7:0] value, input logic closes);
        int gap;
        gap = sender_gaps_on ? pick_idle_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= value;
        s_last_byte <= closes;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_framing(value, closes);
        bytes_sent++;
    endtask

    task automatic send_packet();
        int idx;
        for (idx = 0; idx < packet_bytes.size(); idx++) begin
            send_byte(packet_bytes[idx], idx == packet_bytes.size() - 1);
        end
        packet_bytes.delete();
    endtask

    // Stop offering and wait until every predicted verdict has been checked.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_verdicts.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Hand-picked packets: a lone byte, the smallest valid unit, a bare start
    // code, a zero length, a length with its top bit set, and a valid-looking
    // unit whose header has the forbidden bit.
    task automatic test_directed_framing();
        sender_gaps_on = 1'b1;
        packet_bytes = '{8'h00};
        send_packet();
        packet_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h65};
        send_packet();
        packet_bytes = '{8'h00, 8'h00, 8'h01, 8'h65};
        send_packet();
        packet_bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_packet();
        packet_bytes = '{8'h80, 8'h00, 8'h00, 8'h01, 8'hff};
        send_packet();
        packet_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'he5};
        send_packet();
        wait_for_results();
    endtask

    // The receiver holds off while short packets arrive back to back. The
    // result register fills, a final byte parks in the input register, and the
    // input channel has to stall until the receiver lets go.
    task automatic test_result_backpressure();
        hold_request = 1'b1;
        wait (receiver_held);
        sender_gaps_on = 1'b0;
        repeat (8) begin
            if ($urandom_range(0, 1) == 1) begin
                packet_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, good_header()};
            end else begin
                packet_bytes = '{payload_byte()};
            end
            send_packet();
        end
        wait_for_results();
    endtask

    // Mixed packets with random content. Some packets go out with no gaps at
    // all, and now and then the sender waits for all results to come back.
    task automatic test_random_traffic();
        packet_kind_t kind;
        int           roll;
        int           stop_at;

        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            sender_gaps_on = ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 99);
            if (roll < 45) kind = PKT_LENGTH_PREFIXED;
            else if (roll < 80) kind = PKT_ANNEXB;
            else kind = PKT_NOISE;
            case (kind)
                PKT_LENGTH_PREFIXED: build_length_prefixed();
                PKT_ANNEXB:          build_annexb();
                default:             build_noise();
            endcase
            send_packet();
            if ($urandom_range(0, 19) == 0) wait_for_results();
        end
        wait_for_results();
    endtask

    // ------------------------------------------------------------------------
    // Receiver side. It raises ready for a run of cycles and then drops it for
    // a random stall; a hold request from a test turns into one long stall.
    // ------------------------------------------------------------------------
    initial begin : result_receiver
        int run_len;
        int stall_len;

        m_ready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request  = 1'b0;
                receiver_held = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                receiver_held = 1'b0;
            end else begin
                // Occasional long runs give stretches with no stalls at all.
                run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
                m_ready <= 1'b1;
                repeat (run_len) @(posedge aclk);
                stall_len = pick_idle_gap();
                if (stall_len > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall_len) @(posedge aclk);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker. Values are sampled at the rising edge, before any update
    // of that edge takes effect, so they are the ones the block saw.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        framing_verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_verdicts.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("%0t: result with no packet pending: annexb=%0b avcc=%0b",
                             $time, m_annexb_detected, m_length_prefixed_valid);
                end
            end else begin
                want = expected_verdicts.pop_front();
                if (m_annexb_detected !== want.annexb_detected ||
                    m_length_prefixed_valid !== want.length_prefixed_valid) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("%0t: verdict mismatch: annexb exp %0b got %0b, avcc exp %0b got %0b",
                                 $time, want.annexb_detected, m_annexb_detected,
                                 want.length_prefixed_valid, m_length_prefixed_valid);
                    end
                end
            end
        end
    end

    // Hang detection: any accepted request on either channel restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request accepted for %0d cycles", $time, idle_cycles);
            $display("** h264_stream_format_detector_unit: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        fail_count     = 0;
        bytes_sent     = 0;
        idle_cycles    = 0;
        sender_gaps_on = 1'b1;
        hold_request   = 1'b0;
        receiver_held  = 1'b0;
        s_valid        = 1'b0;
        s_data_byte    = 8'h00;
        s_last_byte    = 1'b0;
        aresetn        = 1'b0;
        clear_framing_state();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_framing();
        test_result_backpressure();
        test_random_traffic();

        // Let any stray result show up before the verdict.
        repeat (8) @(posedge aclk);
        if (expected_verdicts.size() != 0) begin
            fail_count++;
            $display("%0d packets never produced a result", expected_verdicts.size());
        end

        if (fail_count == 0) begin
            $display("** h264_stream_format_detector_unit: PASSED **");
        end else begin
            $display("** h264_stream_format_detector_unit: FAILED **");
        end
        $finish;
    end

endmodule
